// ===== src/bdy_pkg.sv =====
// shared types and constants of the buddy allocator
// used by bdy_shift and buddy_allocator, depends on nothing
`default_nettype none

package bdy_pkg;

  // node states of the allocation tree
  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_ALLOC   = 2'd1,
    ST_PARTIAL = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // modes of the shared shift unit
  typedef enum logic [1:0] {
    SH_LEFT  = 2'd0,
    SH_RIGHT = 2'd1,
    SH_NORM  = 2'd2
  } sh_mode_t;

  localparam int SH_W   = 32;
  localparam int SH_AW  = 6;
  localparam int ORD_W  = 7;
  localparam logic [2:0] SH_FIRST_STEP = 3'd5;

  typedef struct packed {
    logic             start;
    sh_mode_t         mode;
    logic [SH_AW-1:0] amount;
  } sh_req_t;

  typedef struct packed {
    logic             done;
    logic             sticky;
    logic [SH_AW-1:0] count;
  } sh_rsp_t;

  // item fields
  localparam int BYTES_W  = 32;
  localparam int OFFSET_W = 25;
  localparam int COUNT_W  = 6;
  localparam int MIN_W    = 5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_MIN_BLOCK_LOG2 = 1'b0;
  localparam logic [MIN_W-1:0] MIN_BLOCK_LOG2_RESET = 5'd12;

endpackage

`default_nettype wire

// ===== src/bdy_shift.sv =====
// shared shift unit: left or right shift by an amount, or bit-length search
// one power-of-two step per cycle; depends on bdy_pkg
`default_nettype none

module bdy_shift (
  input  logic                      clk,
  input  logic                      rst,
  input  bdy_pkg::sh_req_t          req,
  input  logic [bdy_pkg::SH_W-1:0]  value,
  output bdy_pkg::sh_rsp_t          rsp,
  output logic [bdy_pkg::SH_W-1:0]  result
);

  logic                        running;
  logic                        done;
  logic [2:0]                  step;
  bdy_pkg::sh_mode_t           mode;
  logic [bdy_pkg::SH_AW-1:0]   amt;
  logic [bdy_pkg::SH_W-1:0]    val;
  logic [bdy_pkg::SH_AW-1:0]   cnt;
  logic                        sticky;

  logic [bdy_pkg::SH_W-1:0]    shr;
  logic [bdy_pkg::SH_W-1:0]    shl;
  logic                        lost;
  logic [bdy_pkg::SH_AW-1:0]   hop;

  always_comb begin
    case (step)
      3'd0: begin
        shr = val >> 1;  shl = val << 1;  lost = |val[0:0];  hop = 6'd1;
      end
      3'd1: begin
        shr = val >> 2;  shl = val << 2;  lost = |val[1:0];  hop = 6'd2;
      end
      3'd2: begin
        shr = val >> 4;  shl = val << 4;  lost = |val[3:0];  hop = 6'd4;
      end
      3'd3: begin
        shr = val >> 8;  shl = val << 8;  lost = |val[7:0];  hop = 6'd8;
      end
      3'd4: begin
        shr = val >> 16; shl = val << 16; lost = |val[15:0]; hop = 6'd16;
      end
      default: begin
        shr = '0;        shl = '0;        lost = |val;       hop = 6'd32;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= bdy_pkg::SH_FIRST_STEP;
    end else begin
      if (req.start) begin
        running <= 1'b1;
        done    <= 1'b0;
        step    <= bdy_pkg::SH_FIRST_STEP;
        val     <= value;
        amt     <= req.amount;
        mode    <= req.mode;
        cnt     <= '0;
        sticky  <= 1'b0;
      end else if (running) begin
        case (mode)
          bdy_pkg::SH_LEFT: begin
            if (amt[step]) val <= shl;
          end
          bdy_pkg::SH_RIGHT: begin
            if (amt[step]) begin
              val    <= shr;
              sticky <= sticky | lost;
            end
          end
          bdy_pkg::SH_NORM: begin
            if (shr != '0) begin
              val <= shr;
              cnt <= cnt + hop;
            end
          end
          default: ;
        endcase
        if (step == 3'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step - 3'd1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.sticky = sticky;
  assign rsp.count  = cnt;
  assign result     = val;

endmodule

`default_nettype wire

// ===== src/buddy_allocator.sv =====
// top level of the buddy allocator: sequencer, node status memory, counters
// and register port; depends on bdy_pkg and bdy_shift
//
// Buddy allocator over an implicit binary tree of TREE_LEVELS levels whose
// leaves are blocks of 2^min_block_log2 bytes. One item is worked at a time;
// in_stall is high from acceptance until the result has been loaded into the
// output register, and the next item is taken while that result waits. After
// reset a clearing pass writes every node free before the first item is
// taken. An allocate runs the size search, visits tree nodes on the way down
// and steps back up, updates each ancestor level up to the root and shifts
// the offset; a free scales the offset, visits tree nodes on the way down and
// updates each ancestor level up to the root; each then loads the result.
// The node status memory, with one read and one write port, and the one
// shared shift unit make these steps run one after another.
`default_nettype none

module buddy_allocator #(
  parameter int TREE_LEVELS = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [bdy_pkg::BYTES_W-1:0]         request_bytes,
  input  logic [bdy_pkg::OFFSET_W-1:0]        release_offset,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                ok,
  output logic [bdy_pkg::OFFSET_W-1:0]        block_offset,
  output logic [bdy_pkg::COUNT_W-1:0]         free_blocks,
  output logic [bdy_pkg::COUNT_W-1:0]         occupied_blocks,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bdy_pkg::ADDR_W-1:0]          paddr,
  input  logic [bdy_pkg::DATA_W-1:0]          pwdata,
  output logic [bdy_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int NW    = TREE_LEVELS;
  localparam int PW    = TREE_LEVELS - 1;
  localparam int DW    = (TREE_LEVELS > 2) ? $clog2(TREE_LEVELS) : 1;
  localparam int CW    = TREE_LEVELS;
  localparam int NODES = (2 ** TREE_LEVELS) - 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [DW-1:0] LVL_LAST  = DW'(TREE_LEVELS - 1);
  localparam logic [CW-1:0] ALL_BLOCKS = CW'(2 ** (TREE_LEVELS - 1));

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_LOG,
    S_F_SHR,
    S_FETCH,
    S_EVAL,
    S_BACK,
    S_U_READ,
    S_U_WRITE,
    S_A_SHL,
    S_RESP
  } state_t;

  state_t                           state;
  logic                             kind_r;
  logic [bdy_pkg::OFFSET_W-1:0]     rel_off;
  logic [bdy_pkg::MIN_W-1:0]        min_log2;
  logic [NW-1:0]                    node;
  logic [PW-1:0]                    pos;
  logic [PW-1:0]                    pr;
  logic [DW-1:0]                    lvl;
  logic [DW-1:0]                    tgt;
  logic [bdy_pkg::SH_AW-1:0]        order;
  bdy_pkg::status_t                 cur_st;
  logic [CW-1:0]                    free_cnt;
  logic [CW-1:0]                    used_cnt;
  logic                             res_ok;
  logic [bdy_pkg::OFFSET_W-1:0]     res_off;

  bdy_pkg::status_t                 mem [0:NODES-1];
  bdy_pkg::status_t                 rd_data;
  logic [NW-1:0]                    rd_addr;
  logic                             wr_en;
  logic [NW-1:0]                    wr_addr;
  bdy_pkg::status_t                 wr_data;

  bdy_pkg::sh_req_t                 sh_req;
  bdy_pkg::sh_rsp_t                 sh_rsp;
  logic [bdy_pkg::SH_W-1:0]         sh_value;
  logic [bdy_pkg::SH_W-1:0]         sh_result;

  logic                             accept;
  logic                             cfg_wr;
  logic [bdy_pkg::ORD_W-1:0]        root;
  logic [bdy_pkg::ORD_W-1:0]        bitlen;
  logic [bdy_pkg::ORD_W-1:0]        order_c;
  logic [bdy_pkg::ORD_W-1:0]        depth_c;
  logic                             occ;
  logic                             hit;
  logic                             alloc_back;
  logic                             free_down;
  logic [NW-1:0]                    parent;
  logic [NW-1:0]                    sibling;
  logic [NW-1:0]                    child;
  bdy_pkg::status_t                 par_st;
  bdy_pkg::status_t                 hit_st;
  logic [CW-1:0]                    blocks;
  logic [CW+bdy_pkg::COUNT_W-1:0]   free_wide;
  logic [CW+bdy_pkg::COUNT_W-1:0]   used_wide;

  bdy_shift u_shift (
    .clk    (clk),
    .rst    (rst),
    .req    (sh_req),
    .value  (sh_value),
    .rsp    (sh_rsp),
    .result (sh_result)
  );

  assign accept   = (state == S_IDLE) && in_valid;
  assign in_stall = (state != S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite &&
                    (paddr[bdy_pkg::ADDR_W-1:2] == bdy_pkg::REG_MIN_BLOCK_LOG2);
  assign prdata   = (paddr[bdy_pkg::ADDR_W-1:2] == bdy_pkg::REG_MIN_BLOCK_LOG2) ?
                    bdy_pkg::DATA_W'(min_log2) : '0;

  assign root    = bdy_pkg::ORD_W'(min_log2) + bdy_pkg::ORD_W'(TREE_LEVELS - 1);
  assign bitlen  = bdy_pkg::ORD_W'(sh_rsp.count) + bdy_pkg::ORD_W'(sh_result[0]);
  assign order_c = (bitlen > bdy_pkg::ORD_W'(min_log2)) ? bitlen :
                   bdy_pkg::ORD_W'(min_log2);
  assign depth_c = root - order_c;

  // tree navigation
  assign parent  = (node - NW'(1)) >> 1;
  assign sibling = node[0] ? (node + NW'(1)) : (node - NW'(1));
  assign child   = (node << 1) + NW'(1) + NW'(pr[PW-1]);
  assign blocks  = CW'(1) << (LVL_LAST - lvl);

  assign occ        = (rd_data == bdy_pkg::ST_ALLOC) || (rd_data == bdy_pkg::ST_FULL);
  assign alloc_back = occ || ((lvl == tgt) && (rd_data != bdy_pkg::ST_FREE));
  assign free_down  = ((rd_data == bdy_pkg::ST_PARTIAL) ||
                       (rd_data == bdy_pkg::ST_FULL)) && (lvl != LVL_LAST);
  assign hit        = (kind_r == bdy_pkg::KIND_FREE) ?
                      ((rd_data == bdy_pkg::ST_ALLOC) && (pr == '0)) :
                      ((rd_data == bdy_pkg::ST_FREE) && (lvl == tgt));
  assign hit_st     = (kind_r == bdy_pkg::KIND_FREE) ? bdy_pkg::ST_FREE :
                      bdy_pkg::ST_ALLOC;

  always_comb begin
    if (((cur_st == bdy_pkg::ST_ALLOC) || (cur_st == bdy_pkg::ST_FULL)) &&
        ((rd_data == bdy_pkg::ST_ALLOC) || (rd_data == bdy_pkg::ST_FULL))) begin
      par_st = bdy_pkg::ST_FULL;
    end else if ((cur_st == bdy_pkg::ST_FREE) && (rd_data == bdy_pkg::ST_FREE)) begin
      par_st = bdy_pkg::ST_FREE;
    end else begin
      par_st = bdy_pkg::ST_PARTIAL;
    end
  end

  always_comb begin
    rd_addr = node;
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = bdy_pkg::ST_FREE;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_EVAL: begin
        wr_en   = hit;
        wr_data = hit_st;
      end
      S_U_READ: begin
        rd_addr = sibling;
      end
      S_U_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = parent;
        wr_data = par_st;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    sh_req.start  = 1'b0;
    sh_req.mode   = bdy_pkg::SH_NORM;
    sh_req.amount = bdy_pkg::SH_AW'(min_log2);
    sh_value      = '0;
    if (accept) begin
      sh_req.start = 1'b1;
      if (kind == bdy_pkg::KIND_FREE) begin
        sh_req.mode = bdy_pkg::SH_RIGHT;
        sh_value    = bdy_pkg::SH_W'(release_offset);
      end else begin
        sh_value = (request_bytes == '0) ? '0 : (request_bytes - 32'd1);
      end
    end else if ((state == S_U_READ) && (node == '0) &&
                 (kind_r == bdy_pkg::KIND_ALLOC)) begin
      sh_req.start  = 1'b1;
      sh_req.mode   = bdy_pkg::SH_LEFT;
      sh_req.amount = order;
      sh_value      = bdy_pkg::SH_W'(pos);
    end
  end

  assign free_wide = {{bdy_pkg::COUNT_W{1'b0}}, free_cnt};
  assign used_wide = {{bdy_pkg::COUNT_W{1'b0}}, used_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      node      <= '0;
      out_valid <= 1'b0;
      min_log2  <= bdy_pkg::MIN_BLOCK_LOG2_RESET;
      free_cnt  <= ALL_BLOCKS;
      used_cnt  <= '0;
    end else begin
      if (cfg_wr) min_log2 <= pwdata[bdy_pkg::MIN_W-1:0];
      if (out_valid && !out_stall && (state != S_RESP)) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          node <= node + NW'(1);
          if (node == LAST_NODE) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= kind;
            rel_off <= release_offset;
            state   <= (kind == bdy_pkg::KIND_FREE) ? S_F_SHR : S_A_LOG;
          end
        end
        S_A_LOG: begin
          if (sh_rsp.done) begin
            node  <= '0;
            pos   <= '0;
            lvl   <= '0;
            order <= order_c[bdy_pkg::SH_AW-1:0];
            tgt   <= depth_c[DW-1:0];
            if (order_c > root) begin
              res_ok  <= 1'b0;
              res_off <= '0;
              state   <= S_RESP;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_F_SHR: begin
          if (sh_rsp.done) begin
            node <= '0;
            lvl  <= '0;
            pr   <= sh_result[PW-1:0];
            if (sh_rsp.sticky || ((sh_result >> (TREE_LEVELS - 1)) != '0)) begin
              res_ok  <= 1'b0;
              res_off <= '0;
              state   <= S_RESP;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (hit) begin
            cur_st <= hit_st;
            res_ok <= 1'b1;
            if (kind_r == bdy_pkg::KIND_FREE) begin
              free_cnt <= free_cnt + blocks;
              used_cnt <= used_cnt - blocks;
              res_off  <= rel_off;
            end else begin
              free_cnt <= free_cnt - blocks;
              used_cnt <= used_cnt + blocks;
            end
            state <= S_U_READ;
          end else if (kind_r == bdy_pkg::KIND_FREE) begin
            if (free_down) begin
              node  <= child;
              pr    <= pr << 1;
              lvl   <= lvl + DW'(1);
              state <= S_FETCH;
            end else begin
              res_ok  <= 1'b0;
              res_off <= '0;
              state   <= S_RESP;
            end
          end else if (alloc_back) begin
            state <= S_BACK;
          end else begin
            node  <= (node << 1) + NW'(1);
            pos   <= pos << 1;
            lvl   <= lvl + DW'(1);
            state <= S_FETCH;
          end
        end
        S_BACK: begin
          if (node == '0) begin
            res_ok  <= 1'b0;
            res_off <= '0;
            state   <= S_RESP;
          end else if (node[0]) begin
            node  <= node + NW'(1);
            pos   <= pos + PW'(1);
            state <= S_FETCH;
          end else begin
            node <= parent;
            pos  <= pos >> 1;
            lvl  <= lvl - DW'(1);
          end
        end
        S_U_READ: begin
          if (node == '0) begin
            state <= (kind_r == bdy_pkg::KIND_FREE) ? S_RESP : S_A_SHL;
          end else begin
            state <= S_U_WRITE;
          end
        end
        S_U_WRITE: begin
          node   <= parent;
          cur_st <= par_st;
          state  <= S_U_READ;
        end
        S_A_SHL: begin
          if (sh_rsp.done) begin
            res_off <= sh_result[bdy_pkg::OFFSET_W-1:0];
            state   <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            ok              <= res_ok;
            block_offset    <= res_off;
            free_blocks     <= free_wide[bdy_pkg::COUNT_W-1:0];
            occupied_blocks <= used_wide[bdy_pkg::COUNT_W-1:0];
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
